// ===== src/rvp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvp_pkg
// Shared types and constants for the radial vignette pixel pipeline.
// ----------------------------------------------------------------------------
package rvp_pkg;

	localparam int COORD_W    = 12;
	localparam int CH_W       = 8;
	localparam int DIM_W      = 13;
	localparam int MAX_DIM    = 4096;
	localparam int SUM_W      = 2 * COORD_W + 1;
	localparam int FRAC_SHIFT = 16;
	localparam int RAD_W      = 42;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int SQ_STEPS   = ROOT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int HS_W       = DIM_W + 8;
	localparam int DREM_W     = HS_W + 1;
	localparam int FAC_W      = FRAC_SHIFT + 1;
	localparam int DIV_STEPS  = FAC_W;
	localparam int PROD_W     = CH_W + FAC_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_col;
		logic [COORD_W-1:0] pixel_row;
		logic [CH_W-1:0]    red_in;
		logic [CH_W-1:0]    green_in;
		logic [CH_W-1:0]    blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
	} pix_out_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

endpackage
`default_nettype wire

// ===== src/rvp_dist_sq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvp_dist_sq
// Offsets from the image centre and squared distance, two stages.
// ----------------------------------------------------------------------------
module rvp_dist_sq (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          v_in,
	input  rvp_pkg::pix_in_t             pix,
	input  wire  [rvp_pkg::COORD_W-1:0]  cx,
	input  wire  [rvp_pkg::COORD_W-1:0]  cy,
	output logic                         v_out,
	output logic [rvp_pkg::SUM_W-1:0]    sum,
	output rvp_pkg::rgb_t                rgb
);
	import rvp_pkg::*;

	logic               v_s1, v_s2;
	logic [COORD_W-1:0] dx_s1, dy_s1;
	rgb_t               rgb_s1, rgb_s2;
	logic [SUM_W-1:0]   sum_s2;
	logic [COORD_W-1:0] dx_c, dy_c;
	logic [2*COORD_W-1:0] dx2_c, dy2_c;

	// absolute offsets
	always_comb begin
		dx_c = (pix.pixel_col >= cx) ? pix.pixel_col - cx : cx - pix.pixel_col;
		dy_c = (pix.pixel_row >= cy) ? pix.pixel_row - cy : cy - pix.pixel_row;
	end

	always_comb begin
		dx2_c = dx_s1 * dx_s1;
		dy2_c = dy_s1 * dy_s1;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
			rgb_s1 <= '{red: pix.red_in, green: pix.green_in, blue: pix.blue_in};
			sum_s2 <= {1'b0, dx2_c} + {1'b0, dy2_c};
			rgb_s2 <= rgb_s1;
		end
	end

	assign v_out = v_s2;
	assign sum   = sum_s2;
	assign rgb   = rgb_s2;

endmodule
`default_nettype wire

// ===== src/rvp_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvp_sqrt
// Pipelined digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rvp_sqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          v_in,
	input  wire  [rvp_pkg::SUM_W-1:0]    sum,
	input  rvp_pkg::rgb_t                rgb_in,
	output logic                         v_out,
	output logic [rvp_pkg::ROOT_W-1:0]   root,
	output rvp_pkg::rgb_t                rgb_out
);
	import rvp_pkg::*;

	logic              v_s    [SQ_STEPS];
	logic [REM_W-1:0]  rem_s  [SQ_STEPS];
	logic [ROOT_W-1:0] root_s [SQ_STEPS];
	logic [RAD_W-1:0]  rad_s  [SQ_STEPS];
	rgb_t              rgb_s  [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic              v_c;
		logic [REM_W-1:0]  rem_c;
		logic [ROOT_W-1:0] root_c;
		logic [RAD_W-1:0]  rad_c;
		rgb_t              rgb_c;
		logic [REM_W-1:0]  r2_c, trial_c;
		logic              ge_c;

		// pick up the previous stage, or the new radicand
		if (k == 0) begin : g_first
			assign v_c    = v_in;
			assign rem_c  = '0;
			assign root_c = '0;
			assign rad_c  = {1'b0, sum, {FRAC_SHIFT{1'b0}}};
			assign rgb_c  = rgb_in;
		end else begin : g_next
			assign v_c    = v_s[k-1];
			assign rem_c  = rem_s[k-1];
			assign root_c = root_s[k-1];
			assign rad_c  = rad_s[k-1];
			assign rgb_c  = rgb_s[k-1];
		end

		// trial subtract for one root bit
		always_comb begin
			r2_c    = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
			trial_c = {1'b0, root_c, 2'b01};
			ge_c    = (r2_c >= trial_c);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge_c ? r2_c - trial_c : r2_c;
				root_s[k] <= {root_c[ROOT_W-2:0], ge_c};
				rad_s[k]  <= {rad_c[RAD_W-3:0], 2'b00};
				rgb_s[k]  <= rgb_c;
			end
		end
	end

	assign v_out   = v_s[SQ_STEPS-1];
	assign root    = root_s[SQ_STEPS-1];
	assign rgb_out = rgb_s[SQ_STEPS-1];

endmodule
`default_nettype wire

// ===== src/rvp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvp_div
// Falloff factor: saturating difference, then a restoring divider with one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module rvp_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          v_in,
	input  wire  [rvp_pkg::ROOT_W-1:0]   dist_fx,
	input  wire  [rvp_pkg::HS_W-1:0]     hs,
	input  rvp_pkg::rgb_t                rgb_in,
	output logic                         v_out,
	output logic [rvp_pkg::FAC_W-1:0]    factor,
	output rvp_pkg::rgb_t                rgb_out
);
	import rvp_pkg::*;

	logic              v_s0;
	logic [HS_W-1:0]   diff_s0;
	rgb_t              rgb_s0;
	logic              v_s    [DIV_STEPS];
	logic [DREM_W-1:0] rem_s  [DIV_STEPS];
	logic [FAC_W-1:0]  q_s    [DIV_STEPS];
	rgb_t              rgb_s  [DIV_STEPS];
	logic [DREM_W-1:0] den_c;

	assign den_c = {1'b0, hs};

	// saturate to zero beyond the radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s0 <= (dist_fx < hs) ? hs - dist_fx : '0;
			rgb_s0  <= rgb_in;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic              v_c;
		logic [DREM_W-1:0] r2_c;
		logic [FAC_W-1:0]  q_c;
		rgb_t              rgb_c;
		logic              ge_c;

		// first step compares the plain difference, later ones shift
		if (k == 0) begin : g_first
			assign v_c   = v_s0;
			assign r2_c  = {1'b0, diff_s0};
			assign q_c   = '0;
			assign rgb_c = rgb_s0;
		end else begin : g_next
			assign v_c   = v_s[k-1];
			assign r2_c  = {rem_s[k-1][DREM_W-2:0], 1'b0};
			assign q_c   = q_s[k-1];
			assign rgb_c = rgb_s[k-1];
		end

		assign ge_c = (r2_c >= den_c);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge_c ? r2_c - den_c : r2_c;
				q_s[k]   <= {q_c[FAC_W-2:0], ge_c};
				rgb_s[k] <= rgb_c;
			end
		end
	end

	assign v_out   = v_s[DIV_STEPS-1];
	assign factor  = q_s[DIV_STEPS-1];
	assign rgb_out = rgb_s[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== src/rvp_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvp_scale
// Scales the three channels by the factor and holds the result.
// ----------------------------------------------------------------------------
module rvp_scale (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          v_in,
	input  wire  [rvp_pkg::FAC_W-1:0]    factor,
	input  rvp_pkg::rgb_t                rgb_in,
	output logic                         v_out,
	output rvp_pkg::pix_out_t            pix
);
	import rvp_pkg::*;

	logic            v_s1;
	pix_out_t        pix_s1;
	logic [PROD_W-1:0] pr_c, pg_c, pb_c;

	// channel times factor, drop the fraction
	always_comb begin
		pr_c = PROD_W'(rgb_in.red)   * factor;
		pg_c = PROD_W'(rgb_in.green) * factor;
		pb_c = PROD_W'(rgb_in.blue)  * factor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1.red_out   <= pr_c[FRAC_SHIFT +: CH_W];
			pix_s1.green_out <= pg_c[FRAC_SHIFT +: CH_W];
			pix_s1.blue_out  <= pb_c[FRAC_SHIFT +: CH_W];
		end
	end

	assign v_out = v_s1;
	assign pix   = pix_s1;

endmodule
`default_nettype wire

// ===== src/radial_vignette_pixel.sv =====
`default_nettype none
// Steps from an accepted input transaction to its output: the squared distance,
// the square root, the falloff factor, then the scale.
// Throughput: one pixel per cycle while the output is not stalled; every stage is fully pipelined.
// Reset: clears all valid bits; image width 640 and height 480.
// An output stall while the output is valid freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
// radial_vignette_pixel
// Darkens each pixel by its distance from the image centre.
// ----------------------------------------------------------------------------
module radial_vignette_pixel (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  rvp_pkg::pix_in_t               in_pix,
	output logic                           out_valid,
	input  wire                            out_stall,
	output rvp_pkg::pix_out_t              out_pix,
	input  wire                            cfg_we,
	input  wire  [rvp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [rvp_pkg::DIM_W-1:0]      cfg_data
);
	import rvp_pkg::*;

	logic [DIM_W-1:0]  width_q, height_q;
	logic [DIM_W-1:0]  w_c, h_c;
	logic [HS_W-1:0]   hs_c;
	logic              en;
	logic              v_sq, v_rt, v_fc;
	logic [SUM_W-1:0]  sum;
	logic [ROOT_W-1:0] root;
	logic [FAC_W-1:0]  factor;
	rgb_t              rgb_sq, rgb_rt, rgb_fc;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp dimensions to 1..MAX_DIM
	always_comb begin
		w_c = (width_q == '0) ? DIM_W'(1) :
			(width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_q;
		h_c = (height_q == '0) ? DIM_W'(1) :
			(height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_q;
		hs_c = {h_c, 8'd0};
	end

	// hold everything while the output transaction waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	rvp_dist_sq u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (in_valid),
		.pix    (in_pix),
		.cx     (w_c[DIM_W-1:1]),
		.cy     (h_c[DIM_W-1:1]),
		.v_out  (v_sq),
		.sum    (sum),
		.rgb    (rgb_sq)
	);

	rvp_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_sq),
		.sum     (sum),
		.rgb_in  (rgb_sq),
		.v_out   (v_rt),
		.root    (root),
		.rgb_out (rgb_rt)
	);

	rvp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_rt),
		.dist_fx (root),
		.hs      (hs_c),
		.rgb_in  (rgb_rt),
		.v_out   (v_fc),
		.factor  (factor),
		.rgb_out (rgb_fc)
	);

	rvp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_fc),
		.factor (factor),
		.rgb_in (rgb_fc),
		.v_out  (out_valid),
		.pix    (out_pix)
	);

endmodule
`default_nettype wire

// ===== verif/tb_radial_vignette_pixel.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radial_vignette_pixel
// Drives pixels through the radial vignette pipeline under several image
// sizes, predicts each darkened pixel in fixed point and compares in order.
// ----------------------------------------------------------------------------
module tb_radial_vignette_pixel;
	import rvp_pkg::*;

	localparam int LATENCY     = 42;
	localparam int CYCLE_LIMIT = 400000;

	// Indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	pix_in_t              in_pix;
	logic                 out_valid;
	logic                 out_stall;
	pix_out_t             out_pix;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	// Shadow copy of the size registers
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	pix_out_t dark_pixels_q[$];
	int       mismatches;
	int       cycle_count;
	bit       idle_enable;
	int       hold_off_cycles;

	radial_vignette_pixel u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_pix    (in_pix),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_pix   (out_pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Clamp a size register to the legal range
	function automatic longint unsigned legal_dim(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	// Bitwise integer square root
	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > n) probe >>= 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n    = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	function automatic pix_out_t vignette_pixel(pix_in_t p);
		longint unsigned w, h, cx, cy, dx, dy, dist_fx, hs, factor;
		pix_out_t r;
		w  = legal_dim(width_q);
		h  = legal_dim(height_q);
		cx = w / 2;
		cy = h / 2;
		dx = (p.pixel_col >= cx) ? p.pixel_col - cx : cx - p.pixel_col;
		dy = (p.pixel_row >= cy) ? p.pixel_row - cy : cy - p.pixel_row;
		dist_fx = int_root((dx * dx + dy * dy) << 16);
		hs      = h << 8;
		factor  = 0;
		if (dist_fx < hs) begin
			factor = ((hs - dist_fx) << 16) / hs;
			if (factor > 65536) factor = 65536;
		end
		r.red_out   = 8'((longint'(p.red_in) * factor) >> 16);
		r.green_out = 8'((longint'(p.green_in) * factor) >> 16);
		r.blue_out  = 8'((longint'(p.blue_in) * factor) >> 16);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	// Timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Check each output transaction against the oldest prediction
	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (dark_pixels_q.size() == 0) begin
				report_mismatch("unexpected pixel", int'(out_pix), 0);
			end else begin
				want = dark_pixels_q.pop_front();
				if (out_pix.red_out != want.red_out)
					report_mismatch("red", out_pix.red_out, want.red_out);
				if (out_pix.green_out != want.green_out)
					report_mismatch("green", out_pix.green_out, want.green_out);
				if (out_pix.blue_out != want.blue_out)
					report_mismatch("blue", out_pix.blue_out, want.blue_out);
			end
		end
	end

	// Drive receiver stalls: random idling, or a counted hold-off
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall       <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_stall <= idle_enable && ($urandom_range(99) < 7);
		end
	end

	// Send one pixel, with an optional random gap first; valid stays up
	// until the next call or the drain lowers it
	task automatic send_pixel(pix_in_t p);
		while (idle_enable && ($urandom_range(99) < 7)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_pix   <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		dark_pixels_q = {dark_pixels_q, vignette_pixel(p)};
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (dark_pixels_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH) width_q = v;
		else if (idx == CFG_IMAGE_HEIGHT) height_q = v;
		@(negedge clk);
	endtask

	function automatic pix_in_t random_pixel(int max_coord);
		pix_in_t p;
		p.pixel_col = COORD_W'($urandom_range(max_coord));
		p.pixel_row = COORD_W'($urandom_range(max_coord));
		p.red_in    = CH_W'($urandom);
		p.green_in  = CH_W'($urandom);
		p.blue_in   = CH_W'($urandom);
		return p;
	endfunction

	// Extremes of fields, centre, edge of radius, beyond radius
	task automatic test_directed;
		pix_in_t p;
		p = '{12'd320, 12'd240, 8'hFF, 8'hFF, 8'hFF};
		send_pixel(p);
		p = '{12'd0, 12'd0, 8'hFF, 8'h80, 8'h01};
		send_pixel(p);
		p = '{12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF};
		send_pixel(p);
		p = '{12'd320, 12'd0, 8'h00, 8'h55, 8'hAA};
		send_pixel(p);
		p = '{12'd800, 12'd240, 8'hFF, 8'hFF, 8'hFF};
		send_pixel(p);
		p = '{12'd320, 12'd719, 8'hC3, 8'h3C, 8'h7E};
		send_pixel(p);
		p = '{12'hAAA, 12'h555, 8'hAA, 8'h55, 8'hFF};
		send_pixel(p);
		p = '{12'h555, 12'hAAA, 8'h55, 8'hAA, 8'h00};
		send_pixel(p);
		drain();
	endtask

	// Zero, tiny, oversized and maximum dimensions, plus the unused indexes
	task automatic test_size_extremes;
		write_size(CFG_IMAGE_WIDTH, '0);
		write_size(CFG_IMAGE_HEIGHT, '0);
		write_size(CFG_SPARE_A, 13'd77);
		write_size(CFG_SPARE_B, 13'd99);
		repeat (20) send_pixel(random_pixel(3));
		drain();
		write_size(CFG_IMAGE_WIDTH, 13'h1FFF);
		write_size(CFG_IMAGE_HEIGHT, 13'h1FFF);
		repeat (20) send_pixel(random_pixel(4095));
		drain();
		write_size(CFG_IMAGE_WIDTH, 13'd4096);
		write_size(CFG_IMAGE_HEIGHT, 13'd1);
		repeat (20) send_pixel(random_pixel(4095));
		drain();
	endtask

	// Random sizes, mostly pixels inside the image
	task automatic test_random_sizes;
		int w, h;
		for (int phase = 0; phase < 6; phase++) begin
			w = $urandom_range(1, 4096);
			h = $urandom_range(1, 4096);
			write_size(CFG_IMAGE_WIDTH, DIM_W'(w));
			write_size(CFG_IMAGE_HEIGHT, DIM_W'(h));
			idle_enable = (phase != 2);
			repeat (110) begin
				pix_in_t p;
				p = random_pixel(4095);
				if ($urandom_range(9) < 8) begin
					p.pixel_col = COORD_W'($urandom_range(w - 1));
					p.pixel_row = COORD_W'($urandom_range(h - 1));
				end
				send_pixel(p);
			end
			drain();
		end
		idle_enable = 1'b1;
	endtask

	// Long receiver hold-off while pixels keep coming
	task automatic test_back_pressure;
		write_size(CFG_IMAGE_WIDTH, 13'd64);
		write_size(CFG_IMAGE_HEIGHT, 13'd48);
		hold_off_cycles = 200;
		repeat (80) send_pixel(random_pixel(70));
		drain();
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		in_pix          = '0;
		out_stall       = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		width_q         = 13'd640;
		height_q        = 13'd480;
		mismatches      = 0;
		cycle_count     = 0;
		idle_enable     = 1'b1;
		hold_off_cycles = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_size_extremes();
		test_random_sizes();
		test_back_pressure();

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== radial_vignette_pixel.f =====
src/rvp_pkg.sv
src/rvp_dist_sq.sv
src/rvp_sqrt.sv
src/rvp_div.sv
src/rvp_scale.sv
src/radial_vignette_pixel.sv
verif/tb_radial_vignette_pixel.sv
